// ----- design/mhpq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types, codes and helpers of the max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_W    = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = CNT_W + 1;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic                    op;
		logic signed [KEY_W-1:0] key;
	} in_item_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] removed_key;
		logic [1:0]              status;
		logic [6:0]              occupancy;
	} out_item_t;

	// Heap positions count from one; memory entries count from zero.
	function automatic logic [IDX_W-1:0] pos_to_idx(input logic [POS_W-1:0] pos);
		logic [POS_W-1:0] t;
		t = pos - POS_W'(1);
		return t[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- design/mhpq_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_ram
// Synchronous RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mhpq_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr_a,
	output logic      [WIDTH-1:0]                 rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr_b,
	output logic      [WIDTH-1:0]                 rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
`default_nettype wire

// ----- design/mhpq_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_engine
// Heap sequencer: runs sift-up and sift-down against the heap RAM.
// ----------------------------------------------------------------------------
module mhpq_engine (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire mhpq_pkg::in_item_t   in_item,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output mhpq_pkg::out_item_t       res_item
);

	localparam int POS_W = mhpq_pkg::POS_W;
	localparam int CNT_W = mhpq_pkg::CNT_W;
	localparam int IDX_W = mhpq_pkg::IDX_W;
	localparam int KEY_W = mhpq_pkg::KEY_W;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_UP_START = 3'd1;
	localparam logic [2:0] S_UP_CMP   = 3'd2;
	localparam logic [2:0] S_DN_START = 3'd3;
	localparam logic [2:0] S_DN_LOAD  = 3'd4;
	localparam logic [2:0] S_DN_CMP   = 3'd5;
	localparam logic [2:0] S_WR_ITEM  = 3'd6;
	localparam logic [2:0] S_RES      = 3'd7;

	logic [2:0]              state_q;
	logic [CNT_W-1:0]        count_q;
	logic [POS_W-1:0]        pos_q;
	logic [POS_W-1:0]        child_q;
	logic signed [KEY_W-1:0] item_q;
	logic signed [KEY_W-1:0] removed_q;
	logic [1:0]              status_q;

	logic                    we;
	logic [IDX_W-1:0]        waddr;
	logic [KEY_W-1:0]        wdata;
	logic [IDX_W-1:0]        raddr_a;
	logic [IDX_W-1:0]        raddr_b;
	logic [KEY_W-1:0]        rdata_a;
	logic [KEY_W-1:0]        rdata_b;

	logic [POS_W-1:0]        cnt_ext;
	logic [POS_W-1:0]        up_parent;
	logic                    up_greater;
	logic                    take_right;
	logic [POS_W-1:0]        dn_child;
	logic signed [KEY_W-1:0] dn_val;
	logic                    dn_greater;
	logic [POS_W-1:0]        dn_next;

	mhpq_ram #(
		.DEPTH(mhpq_pkg::CAPACITY),
		.WIDTH(KEY_W)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	assign cnt_ext    = POS_W'(count_q);
	assign up_parent  = pos_q >> 1;
	assign up_greater = item_q > $signed(rdata_a);
	// The right child wins only when it exists and is strictly larger.
	assign take_right = (child_q < cnt_ext) && ($signed(rdata_b) > $signed(rdata_a));
	assign dn_child   = take_right ? child_q + POS_W'(1) : child_q;
	assign dn_val     = take_right ? $signed(rdata_b) : $signed(rdata_a);
	assign dn_greater = dn_val > item_q;
	assign dn_next    = dn_child << 1;

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RES);

	always_comb begin
		res_item.removed_key = removed_q;
		res_item.status      = status_q;
		res_item.occupancy   = 7'(count_q);
	end

	// RAM port control. Every read whose data is used targets an address
	// other than the one written in the same cycle, so no forwarding path is needed.
	always_comb begin
		we      = 1'b0;
		waddr   = '0;
		wdata   = item_q;
		raddr_a = '0;
		raddr_b = '0;
		case (state_q)
			S_UP_START: begin
				if (pos_q == POS_W'(1)) begin
					we    = 1'b1;
					waddr = mhpq_pkg::pos_to_idx(pos_q);
				end else begin
					raddr_a = mhpq_pkg::pos_to_idx(up_parent);
				end
			end
			S_UP_CMP: begin
				we    = 1'b1;
				waddr = mhpq_pkg::pos_to_idx(pos_q);
				if (up_greater) begin
					wdata   = rdata_a;
					raddr_a = mhpq_pkg::pos_to_idx(up_parent >> 1);
				end
			end
			S_DN_START: begin
				raddr_a = mhpq_pkg::pos_to_idx(POS_W'(1));
				raddr_b = mhpq_pkg::pos_to_idx(cnt_ext);
			end
			S_DN_LOAD: begin
				if (count_q != '0 && cnt_ext < POS_W'(2)) begin
					we    = 1'b1;
					waddr = mhpq_pkg::pos_to_idx(POS_W'(1));
					wdata = rdata_b;
				end
				raddr_a = mhpq_pkg::pos_to_idx(POS_W'(2));
				raddr_b = mhpq_pkg::pos_to_idx(POS_W'(3));
			end
			S_DN_CMP: begin
				we    = 1'b1;
				waddr = mhpq_pkg::pos_to_idx(pos_q);
				if (dn_greater) begin
					wdata   = dn_val;
					raddr_a = mhpq_pkg::pos_to_idx(dn_next);
					raddr_b = mhpq_pkg::pos_to_idx(dn_next + POS_W'(1));
				end
			end
			S_WR_ITEM: begin
				we    = 1'b1;
				waddr = mhpq_pkg::pos_to_idx(pos_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						removed_q <= '0;
						status_q  <= mhpq_pkg::STATUS_OK;
						item_q    <= in_item.key;
						if (in_item.op == mhpq_pkg::OP_INSERT) begin
							if (count_q == CNT_W'(mhpq_pkg::CAPACITY)) begin
								status_q <= mhpq_pkg::STATUS_FULL;
								state_q  <= S_RES;
							end else begin
								count_q <= count_q + CNT_W'(1);
								pos_q   <= cnt_ext + POS_W'(1);
								state_q <= S_UP_START;
							end
						end else begin
							if (count_q == '0) begin
								status_q <= mhpq_pkg::STATUS_EMPTY;
								state_q  <= S_RES;
							end else begin
								state_q <= S_DN_START;
							end
						end
					end
				end
				S_UP_START: begin
					state_q <= (pos_q == POS_W'(1)) ? S_RES : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (up_greater) begin
						pos_q <= up_parent;
						if (up_parent == POS_W'(1)) begin
							state_q <= S_WR_ITEM;
						end
					end else begin
						state_q <= S_RES;
					end
				end
				S_DN_START: begin
					count_q <= count_q - CNT_W'(1);
					state_q <= S_DN_LOAD;
				end
				S_DN_LOAD: begin
					removed_q <= $signed(rdata_a);
					item_q    <= $signed(rdata_b);
					pos_q     <= POS_W'(1);
					child_q   <= POS_W'(2);
					if (cnt_ext < POS_W'(2)) begin
						state_q <= S_RES;
					end else begin
						state_q <= S_DN_CMP;
					end
				end
				S_DN_CMP: begin
					if (dn_greater) begin
						pos_q   <= dn_child;
						child_q <= dn_next;
						if (dn_next > cnt_ext) begin
							state_q <= S_WR_ITEM;
						end
					end else begin
						state_q <= S_RES;
					end
				end
				S_WR_ITEM: begin
					state_q <= S_RES;
				end
				S_RES: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- design/max_heap_priority_queue_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// max_heap_priority_queue_top
// Binary max-heap priority queue over signed 32-bit keys.
// ----------------------------------------------------------------------------
// Usage:
// Each input item on in_valid/in_ready/in_item is either an insert of
// in_item.key or a delete of the current maximum. Every item produces exactly
// one result item on out_valid/out_ready/out_item, carrying the removed key
// (zero unless a delete succeeded), a status code and the occupancy after
// the operation. A delete on an empty heap and an insert into a full heap
// leave the heap untouched and report their status.
// The key moves at most six levels for an insert and five for a delete at a
// capacity of 64. Each level takes one comparison and one write-back, with
// the next level's reads issued in the same cycle.
// One item is worked on at a time; the next item is accepted in the cycle
// after the previous result has moved into the output register. A stalled
// receiver holds out_item steady and, once the engine has a second result
// ready, stops further acceptance.
// Reset clears the element count and all handshake state. The heap RAM is
// not cleared, since no entry's read data is used before it has been written.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire mhpq_pkg::in_item_t   in_item,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output mhpq_pkg::out_item_t       out_item
);

	logic                res_valid;
	logic                res_ready;
	mhpq_pkg::out_item_t res_item;

	logic                out_valid_q;
	mhpq_pkg::out_item_t out_item_q;

	mhpq_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	// The output register takes a new result whenever it is empty or its
	// current item leaves in the same cycle.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_item_q <= res_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef SYNTHESIS
	// A full-heap refusal is reported only when the heap is at capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == mhpq_pkg::STATUS_FULL
		|-> out_item.occupancy == 7'(mhpq_pkg::CAPACITY))
		else $error("full status with heap below capacity");

	// An empty-heap delete reports an empty heap and no key.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == mhpq_pkg::STATUS_EMPTY
		|-> out_item.occupancy == 7'd0 && out_item.removed_key == '0)
		else $error("empty status with keys held or a key returned");

	// The engine is busy in the cycle after taking an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("engine accepted items on consecutive cycles");

	// Occupancy never exceeds the capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.occupancy <= 7'(mhpq_pkg::CAPACITY))
		else $error("occupancy above capacity");
`endif

endmodule
`default_nettype wire
